// ===== sv/svf2x_pkg.sv =====
// Package for the 2x oversampled state variable filter.
// Holds widths, register indexes, mode codes, command types and shared arithmetic.
// No dependencies.
`default_nettype none

package svf2x_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int FRAC_ALIGN   = 24;
   localparam int ALIGN_UP     = (SAMPLE_WIDTH >= FRAC_ALIGN) ? SAMPLE_WIDTH - FRAC_ALIGN : 0;
   localparam int ALIGN_DN     = (SAMPLE_WIDTH >= FRAC_ALIGN) ? 0 : FRAC_ALIGN - SAMPLE_WIDTH;

   localparam int INT_W      = 32;
   localparam int CUTOFF_W   = 16;
   localparam int COEF_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int MODE_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int HALF_W     = COEF_W / 2;
   localparam int MUL_B_W    = INT_W + 1;
   localparam int MUL_A_W    = HALF_W + 1;
   localparam int PROD_W     = MUL_B_W + MUL_A_W;
   localparam int SUM_W      = PROD_W + HALF_W + 1;
   localparam int GX_W       = INT_W + 2;
   localparam int OSUM_W     = INT_W + 3;
   localparam int FRAC_SHIFT = 30;
   localparam int COEF_SHIFT = 2;

   localparam logic [COEF_W-1:0] FREQ_SCALE_RESET = COEF_W'(194783);

   localparam logic [CSR_ADDR_W-1:0] CSR_BYPASS     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE       = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_FREQ_SCALE = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_DAMPING    = CSR_ADDR_W'(3);
   localparam logic [CSR_ADDR_W-1:0] CSR_INPUT_GAIN = CSR_ADDR_W'(4);

   localparam logic [MODE_W-1:0] MODE_LOW      = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_HIGH     = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_BAND     = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_NOTCH    = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_LOW_HIGH = MODE_W'(4);

   typedef enum logic [1:0] {
      SEL_A_CUTOFF,
      SEL_A_GAIN,
      SEL_A_COEF,
      SEL_A_DAMP
   } a_sel_type;

   typedef enum logic [1:0] {
      SEL_B_SCALE,
      SEL_B_SAMPLE,
      SEL_B_BAND,
      SEL_B_HIGH
   } b_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SET_COEF,
      OP_ACC_LO,
      OP_SET_GX,
      OP_SET_LOW,
      OP_SET_HIGH,
      OP_SET_BAND,
      OP_ADD_CONTRIB,
      OP_LOAD_OUT,
      OP_LOAD_BYPASS
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      upper;
   } dp_cmd_type;

   typedef struct packed {
      logic bypass;
   } dp_status_type;

   function automatic logic signed [INT_W-1:0] sat_int(input logic signed [SUM_W-1:0] v);
      logic signed [INT_W-1:0] r;
      if ((&v[SUM_W-1:INT_W-1]) || !(|v[SUM_W-1:INT_W-1])) begin
         r = v[INT_W-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(INT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(INT_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [MUL_B_W-1:0] to_internal(
      input logic signed [SAMPLE_WIDTH-1:0] s);
      logic signed [MUL_B_W+ALIGN_DN-1:0] w;
      w = s;
      w = (w <<< ALIGN_DN) >>> ALIGN_UP;
      return w[MUL_B_W-1:0];
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] to_output(input logic signed [OSUM_W-1:0] v);
      logic signed [OSUM_W+ALIGN_UP-1:0] w;
      logic [SAMPLE_WIDTH-1:0]           r;
      w = v;
      w = (w <<< ALIGN_UP) >>> ALIGN_DN;
      if ((&w[OSUM_W+ALIGN_UP-1:SAMPLE_WIDTH-1]) ||
          !(|w[OSUM_W+ALIGN_UP-1:SAMPLE_WIDTH-1])) begin
         r = w[SAMPLE_WIDTH-1:0];
      end else if (w[OSUM_W+ALIGN_UP-1]) begin
         r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [OSUM_W-1:0] contrib(
      input logic [MODE_W-1:0]       mode,
      input logic signed [INT_W-1:0] low,
      input logic signed [INT_W-1:0] high,
      input logic signed [INT_W-1:0] band);
      logic signed [OSUM_W-1:0] l;
      logic signed [OSUM_W-1:0] h;
      logic signed [OSUM_W-1:0] b;
      logic signed [OSUM_W-1:0] r;
      l = low;
      h = high;
      b = band;
      unique case (mode)
         MODE_LOW:      r = l;
         MODE_HIGH:     r = h;
         MODE_BAND:     r = b;
         MODE_NOTCH:    r = h + l;
         MODE_LOW_HIGH: r = l - h;
         default:       r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/svf2x_dp.sv =====
// Datapath of the state variable filter: configuration registers, shared multiplier,
// partial product accumulator, integrators and output register.
// Depends on svf2x_pkg.
`default_nettype none

module svf2x_dp
   import svf2x_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [CSR_ADDR_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]          csr_data,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_audio_sample,
   input  wire logic [CUTOFF_W-1:0]            req_cutoff_hz,
   input  wire dp_cmd_type                     cmd,
   output dp_status_type                       status,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_filtered_sample
);

   logic                     bypass_ff;
   logic [MODE_W-1:0]        mode_ff;
   logic [COEF_W-1:0]        freq_scale_ff;
   logic [GAIN_W-1:0]        damping_ff;
   logic [GAIN_W-1:0]        gain_ff;
   logic signed [INT_W-1:0]  low_ff;
   logic signed [INT_W-1:0]  band_ff;

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic [CUTOFF_W-1:0]            cutoff_ff;
   logic [COEF_W-1:0]              coef_ff;
   logic signed [GX_W-1:0]         gx_ff;
   logic signed [INT_W-1:0]        high_ff;
   logic signed [OSUM_W-1:0]       out_sum_ff;
   logic signed [PROD_W-1:0]       acc_ff;
   logic signed [PROD_W-1:0]       prod_ff;
   logic [SAMPLE_WIDTH-1:0]        out_ff;

   logic signed [PROD_W-1:0]  prod_in;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [COEF_W-1:0]         mul_a_src;
   logic [HALF_W-1:0]         mul_a;
   logic signed [SUM_W-1:0]   acc_ext;
   logic signed [SUM_W-1:0]   prod_ext;
   logic signed [SUM_W-1:0]   full_sum;
   logic signed [SUM_W-1:0]   scaled;
   logic signed [SUM_W-1:0]   low_ext;
   logic signed [SUM_W-1:0]   band_ext;
   logic signed [SUM_W-1:0]   gx_ext;
   logic [COEF_W-1:0]         coef_in;

   always_comb begin
      unique case (cmd.b_sel)
         SEL_B_SCALE:  mul_b = {1'b0, freq_scale_ff};
         SEL_B_SAMPLE: mul_b = to_internal(sample_ff);
         SEL_B_BAND:   mul_b = MUL_B_W'(band_ff);
         SEL_B_HIGH:   mul_b = MUL_B_W'(high_ff);
         default:      mul_b = '0;
      endcase
      unique case (cmd.a_sel)
         SEL_A_CUTOFF: mul_a_src = COEF_W'(cutoff_ff);
         SEL_A_GAIN:   mul_a_src = COEF_W'(gain_ff);
         SEL_A_COEF:   mul_a_src = coef_ff;
         SEL_A_DAMP:   mul_a_src = COEF_W'(damping_ff);
         default:      mul_a_src = '0;
      endcase
      mul_a   = cmd.upper ? mul_a_src[COEF_W-1:HALF_W] : mul_a_src[HALF_W-1:0];
      prod_in = mul_b * $signed({1'b0, mul_a});
   end

   assign acc_ext  = acc_ff;
   assign prod_ext = prod_ff;
   assign full_sum = acc_ext + (prod_ext <<< HALF_W);
   assign scaled   = full_sum >>> FRAC_SHIFT;
   assign low_ext  = low_ff;
   assign band_ext = band_ff;
   assign gx_ext   = gx_ff;

   assign coef_in = (|prod_ff[PROD_W-1:COEF_W+COEF_SHIFT]) ? {COEF_W{1'b1}} :
                    prod_ff[COEF_W+COEF_SHIFT-1:COEF_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff     <= 1'b0;
         mode_ff       <= MODE_LOW;
         freq_scale_ff <= FREQ_SCALE_RESET;
         damping_ff    <= '0;
         gain_ff       <= '0;
         low_ff        <= '0;
         band_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_BYPASS:     bypass_ff     <= csr_data[0];
               CSR_MODE:       mode_ff       <= csr_data[MODE_W-1:0];
               CSR_FREQ_SCALE: freq_scale_ff <= csr_data[COEF_W-1:0];
               CSR_DAMPING:    damping_ff    <= csr_data[GAIN_W-1:0];
               CSR_INPUT_GAIN: gain_ff       <= csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_SET_LOW) begin
            low_ff <= sat_int(low_ext + scaled);
         end
         if (cmd.op == OP_SET_BAND) begin
            band_ff <= sat_int(band_ext + scaled);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         OP_CAPTURE: begin
            sample_ff  <= req_audio_sample;
            cutoff_ff  <= req_cutoff_hz;
            out_sum_ff <= '0;
         end
         OP_SET_COEF:    coef_ff    <= coef_in;
         OP_ACC_LO:      acc_ff     <= prod_ff;
         OP_SET_GX:      gx_ff      <= scaled[GX_W-1:0];
         OP_SET_HIGH:    high_ff    <= sat_int(gx_ext - low_ext - scaled);
         OP_ADD_CONTRIB: out_sum_ff <= out_sum_ff + contrib(mode_ff, low_ff, high_ff, band_ff);
         OP_LOAD_OUT:    out_ff     <= to_output(out_sum_ff >>> 1);
         OP_LOAD_BYPASS: out_ff     <= sample_ff;
         default: ;
      endcase
   end

   assign status.bypass       = bypass_ff;
   assign rsp_filtered_sample = out_ff;

endmodule

`default_nettype wire

// ===== sv/svf2x_ctrl.sv =====
// Controller of the state variable filter: sequences the shared multiplier
// through the coefficient, input scaling and two filter passes, and owns both handshakes.
// Depends on svf2x_pkg.
`default_nettype none

module svf2x_ctrl
   import svf2x_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FQ_MUL,
      ST_FQ_SET,
      ST_GX_LO,
      ST_GX_HI,
      ST_GX_SET,
      ST_LOW_LO,
      ST_LOW_HI,
      ST_LOW_SET,
      ST_DAMP_LO,
      ST_DAMP_HI,
      ST_HIGH_SET,
      ST_BAND_LO,
      ST_BAND_HI,
      ST_BAND_SET,
      ST_SUM,
      ST_DONE,
      ST_BYPASS
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      pass_ff;
   logic      pass_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '{op: OP_NONE, a_sel: SEL_A_CUTOFF, b_sel: SEL_B_SCALE, upper: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op   = OP_CAPTURE;
               pass_in  = 1'b0;
               state_in = status.bypass ? ST_BYPASS : ST_FQ_MUL;
            end
         end
         ST_FQ_MUL: begin
            state_in = ST_FQ_SET;
         end
         ST_FQ_SET: begin
            cmd.op   = OP_SET_COEF;
            state_in = ST_GX_LO;
         end
         ST_GX_LO: begin
            cmd.a_sel = SEL_A_GAIN;
            cmd.b_sel = SEL_B_SAMPLE;
            state_in  = ST_GX_HI;
         end
         ST_GX_HI: begin
            cmd       = '{op: OP_ACC_LO, a_sel: SEL_A_GAIN, b_sel: SEL_B_SAMPLE, upper: 1'b1};
            state_in  = ST_GX_SET;
         end
         ST_GX_SET: begin
            cmd.op   = OP_SET_GX;
            state_in = ST_LOW_LO;
         end
         ST_LOW_LO: begin
            cmd.a_sel = SEL_A_COEF;
            cmd.b_sel = SEL_B_BAND;
            state_in  = ST_LOW_HI;
         end
         ST_LOW_HI: begin
            cmd      = '{op: OP_ACC_LO, a_sel: SEL_A_COEF, b_sel: SEL_B_BAND, upper: 1'b1};
            state_in = ST_LOW_SET;
         end
         ST_LOW_SET: begin
            cmd.op   = OP_SET_LOW;
            state_in = ST_DAMP_LO;
         end
         ST_DAMP_LO: begin
            cmd.a_sel = SEL_A_DAMP;
            cmd.b_sel = SEL_B_BAND;
            state_in  = ST_DAMP_HI;
         end
         ST_DAMP_HI: begin
            cmd      = '{op: OP_ACC_LO, a_sel: SEL_A_DAMP, b_sel: SEL_B_BAND, upper: 1'b1};
            state_in = ST_HIGH_SET;
         end
         ST_HIGH_SET: begin
            cmd.op   = OP_SET_HIGH;
            state_in = ST_BAND_LO;
         end
         ST_BAND_LO: begin
            cmd.a_sel = SEL_A_COEF;
            cmd.b_sel = SEL_B_HIGH;
            state_in  = ST_BAND_HI;
         end
         ST_BAND_HI: begin
            cmd      = '{op: OP_ACC_LO, a_sel: SEL_A_COEF, b_sel: SEL_B_HIGH, upper: 1'b1};
            state_in = ST_BAND_SET;
         end
         ST_BAND_SET: begin
            cmd.op   = OP_SET_BAND;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op = OP_ADD_CONTRIB;
            if (pass_ff) begin
               state_in = ST_DONE;
            end else begin
               pass_in  = 1'b1;
               state_in = ST_LOW_LO;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op       = OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_BYPASS: begin
            if (out_free) begin
               cmd.op       = OP_LOAD_BYPASS;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/state_variable_filter_2x.sv =====
// Top level of the 2x oversampled Chamberlin state variable filter.
// Depends on svf2x_pkg, svf2x_ctrl and svf2x_dp.
//
// Samples arrive on the req_ channel (audio sample and cutoff in hertz) and
// filtered samples leave on the rsp_ channel; a transaction completes on a
// rising clock edge with valid high and stall low. The csr_ port writes the
// bypass, mode, frequency scale, damping and input gain registers; it must be
// written only while the filter is idle, which the block itself does not enforce.
// One sample is processed at a time. A bypassed sample goes straight to the
// output register, and a new sample can be accepted in the same cycle as a
// result appears. The single 33 by 17 bit multiplier forms each wide product
// from two partial products, and the frequency coefficient from a single one.
// The output register holds a finished sample while the receiver stalls, and
// the filter may take the next sample meanwhile; it then waits at the end of
// that sample until the register is free.
// Synchronous reset clears the integrators, restores the register defaults
// and empties the output register.
`default_nettype none

module state_variable_filter_2x
   import svf2x_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [CSR_ADDR_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]          csr_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_audio_sample,
   input  wire logic [CUTOFF_W-1:0]            req_cutoff_hz,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_filtered_sample
);

   dp_cmd_type    cmd;
   dp_status_type status;

   svf2x_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   svf2x_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_audio_sample    (req_audio_sample),
      .req_cutoff_hz       (req_cutoff_hz),
      .cmd                 (cmd),
      .status              (status),
      .rsp_filtered_sample (rsp_filtered_sample)
   );

endmodule

`default_nettype wire
